// File: hdl/wrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants of the Wilder RSI stream block
// Widths of the average datapath, register map, sequencer states and the
// request and response of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package wrs_pkg;

  // Averages and the shared adder wrap at 64 bits; the RSI ratio uses WORK_W bits
  localparam int AVG_W      = 64;
  localparam int OUT_W      = 32;
  localparam int PERIOD_W   = 11;
  localparam int UNSTABLE_W = 16;
  localparam int IDX_W      = 17;

  // RSI numerator is gain * 100 * 2^16; 100 needs 7 bits
  localparam int RSI_MUL_W  = 7;
  localparam int RSI_FRAC   = 16;
  localparam int PROD_W     = AVG_W + RSI_MUL_W;
  localparam int WORK_W     = PROD_W + RSI_FRAC;
  localparam int CNT_W      = $clog2(WORK_W);

  // APB register map
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EARLY    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_UNSTABLE = 2'd2;

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 11'd14;
  localparam logic [IDX_W-1:0]      IDX_MAX        = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_ADDMAG,
    ST_DIV_LOAD,
    ST_DIV,
    ST_TOTAL,
    ST_PROD_A,
    ST_PROD_B,
    ST_RSI,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [AVG_W-1:0] a;
    logic [AVG_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [AVG_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

endpackage

// File: hdl/wilder_rsi_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilder_rsi_stream: streaming Wilder relative strength index
// One price sample in per transaction, zero or one RSI value out, computed
// by a small sequencer around one shared 64-bit add/subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (price, restart) and output channel (rsi_value) each use
//   valid/stall; a transaction completes when valid is high and stall low.
//   in_stall is high from the accepting edge until the sample is finished,
//   so one sample is in flight at a time; the next sample is accepted as
//   soon as the sequencer is back in idle.
//   Work per sample, after acceptance:
//     pass-through (period 1): the price bits go to the result register
//     first sample of a series: averages cleared, back to idle
//     warm-up sample, no result: two divisions (a load and the steps each)
//     smoothing sample, no result: adds a multiply per lane and one add
//     sample with a result: adds the gain + loss total and the ratio
//   A zero total skips the ratio and loads a zero result.
//   Every multiply, divide and ratio step goes through the one shared
//   adder; the gain * 100 product has its own adders.
//   A finished result waits in the output register; while the receiver
//   stalls and that register is full, the sequencer holds in its emit state
//   and the input stays stalled.
//   Reset (rst, synchronous) restores period 14, normal mode, no unstable
//   period, clears the sample index and averages and drops any pending
//   result. Configuration goes through the APB port at byte addresses 0, 4,
//   8; the user must write it only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module wilder_rsi_stream
  import wrs_pkg::*;
#(
  parameter int PRICE_WIDTH            = 32,
  parameter int AVERAGE_EXTRA_FRACTION = 16
) (
  input  logic                          clk,
  input  logic                          rst,

  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,

  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [PRICE_WIDTH-1:0] price,
  input  logic                          restart,

  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_W-1:0]       rsi_value
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PERIOD_W-1:0]   period;
  logic                  early_mode;
  logic [UNSTABLE_W-1:0] unstable_period;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= PERIOD_RESET;
      early_mode      <= 1'b0;
      unstable_period <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_PERIOD:   period          <= pwdata[PERIOD_W-1:0];
        REG_EARLY:    early_mode      <= pwdata[0];
        REG_UNSTABLE: unstable_period <= pwdata[UNSTABLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD:   prdata = PDATA_W'(period);
      REG_EARLY:    prdata = PDATA_W'(early_mode);
      REG_UNSTABLE: prdata = PDATA_W'(unstable_period);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                 state, state_next;

  logic [PRICE_WIDTH-1:0] price_q;
  logic                   restart_q;
  logic [PRICE_WIDTH-1:0] prev_price;
  logic [IDX_W-1:0]       sample_index;

  logic [AVG_W-1:0]       avg_gain, avg_loss;
  logic [AVG_W-1:0]       tmp_gain, tmp_loss;
  logic [AVG_W-1:0]       mag_q;
  logic                   loss_q;
  logic                   emit_q, early_q, smooth_q;

  logic [OUT_W-1:0]       value;
  logic [WORK_W-1:0]      work;       // dividend shifts out, quotient shifts in
  logic [AVG_W-1:0]       rem;        // remainder, or multiply accumulator
  logic [AVG_W-1:0]       divisor;
  logic [CNT_W-1:0]       count;
  logic                   lane;       // 0 works on gain, 1 on loss
  logic [PERIOD_W-1:0]    multiplier;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  wrs_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // --------------------------------------------------------------------------
  // Decisions for the sample in hand
  // --------------------------------------------------------------------------
  logic [PERIOD_W-1:0]    p_eff, pm1;
  logic [IDX_W-1:0]       k;
  logic [IDX_W:0]         lookback;
  logic                   p_one, k_zero, k_above, k_below, emit_now;
  logic signed [PRICE_WIDTH:0] diff;
  logic [PRICE_WIDTH:0]   mag_now;
  logic                   loss_now;
  logic [AVG_W-1:0]       mag_ext;
  logic                   mul_last, div_last, rsi_last, out_free;
  logic [AVG_W-1:0]       lane_avg, side_avg, div_a;
  logic [PROD_W-1:0]      gain_prod;

  // Period zero behaves as period one
  assign p_eff    = (period == '0) ? PERIOD_W'(1) : period;
  assign pm1      = p_eff - PERIOD_W'(1);
  assign p_one    = (p_eff == PERIOD_W'(1));
  assign k        = restart_q ? '0 : sample_index;
  assign k_zero   = (k == '0);
  assign k_above  = (k > IDX_W'(p_eff));
  assign k_below  = (k < IDX_W'(p_eff));
  assign lookback = (IDX_W+1)'(p_eff) + (IDX_W+1)'(unstable_period)
                  - (IDX_W+1)'(early_mode);
  assign emit_now = ({1'b0, k} >= lookback);

  assign diff     = $signed({price_q[PRICE_WIDTH-1], price_q})
                  - $signed({prev_price[PRICE_WIDTH-1], prev_price});
  assign loss_now = diff[PRICE_WIDTH];
  assign mag_now  = loss_now ? $unsigned(-diff) : $unsigned(diff);
  assign mag_ext  = AVG_W'(mag_now);

  assign mul_last = (count == CNT_W'(PERIOD_W-1));
  assign div_last = (count == CNT_W'(AVG_W-1));
  assign rsi_last = (count == CNT_W'(WORK_W-1));
  assign out_free = !out_valid || !out_stall;

  assign lane_avg  = lane ? avg_loss : avg_gain;
  assign side_avg  = (state == ST_START) ? (loss_now ? avg_loss : avg_gain)
                                         : (loss_q ? avg_loss : avg_gain);
  assign div_a     = {rem[AVG_W-2:0], work[WORK_W-1]};
  assign gain_prod = PROD_W'(tmp_gain);

  assign in_stall  = rst || (state != ST_IDLE);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        if (p_one || k_zero)  state_next = emit_now ? ST_EMIT : ST_IDLE;
        else if (k_above)     state_next = ST_MUL;
        else                  state_next = ST_DIV_LOAD;
      end
      ST_MUL: begin
        if (mul_last && lane) state_next = ST_ADDMAG;
      end
      ST_ADDMAG:   state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_last) state_next = lane ? ST_TOTAL : ST_DIV_LOAD;
      end
      ST_TOTAL: begin
        if (!emit_q)                state_next = ST_IDLE;
        else if (alu_rsp.sum == '0) state_next = ST_EMIT;
        else                        state_next = ST_PROD_A;
      end
      ST_PROD_A: state_next = ST_PROD_B;
      ST_PROD_B: state_next = ST_RSI;
      ST_RSI: begin
        if (rsi_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: operands of the shared adder
  // --------------------------------------------------------------------------
  always_comb begin
    alu_req = '0;
    unique case (state)
      ST_START: begin
        alu_req.a = side_avg;
        alu_req.b = mag_ext;
      end
      ST_MUL: begin
        // shift-add, multiplier bits from the top
        alu_req.a = {rem[AVG_W-2:0], 1'b0};
        alu_req.b = multiplier[PERIOD_W-1] ? lane_avg : '0;
      end
      ST_ADDMAG: begin
        alu_req.a = side_avg;
        alu_req.b = mag_q << AVERAGE_EXTRA_FRACTION;
      end
      ST_DIV, ST_RSI: begin
        alu_req.a   = div_a;
        alu_req.b   = divisor;
        alu_req.sub = 1'b1;
      end
      ST_TOTAL: begin
        alu_req.a = tmp_gain;
        alu_req.b = tmp_loss;
      end
      default: alu_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      prev_price   <= '0;
      avg_gain     <= '0;
      avg_loss     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // drop the result once the receiver takes it; the emit state reloads
      if (out_valid && !out_stall && (state != ST_EMIT)) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            price_q   <= price;
            restart_q <= restart;
          end
        end

        ST_START: begin
          prev_price   <= price_q;
          sample_index <= (k < IDX_MAX) ? k + IDX_W'(1) : IDX_MAX;
          mag_q        <= mag_ext;
          loss_q       <= loss_now;
          emit_q       <= emit_now;
          early_q      <= k_below;
          smooth_q     <= k_above;
          lane         <= 1'b0;
          count        <= '0;
          rem          <= '0;
          multiplier   <= pm1;
          if (p_one) begin
            // pass the price bits straight through
            value <= OUT_W'(AVG_W'(price_q));
          end else if (k_zero) begin
            avg_gain <= '0;
            avg_loss <= '0;
            value    <= '0;
          end else if (!k_above) begin
            // raw sums while warming up
            if (loss_now) avg_loss <= alu_rsp.sum;
            else          avg_gain <= alu_rsp.sum;
          end
        end

        ST_MUL: begin
          if (mul_last) begin
            if (lane) avg_loss <= alu_rsp.sum;
            else      avg_gain <= alu_rsp.sum;
            lane       <= 1'b1;
            rem        <= '0;
            count      <= '0;
            multiplier <= pm1;
          end else begin
            rem        <= alu_rsp.sum;
            multiplier <= {multiplier[PERIOD_W-2:0], 1'b0};
            count      <= count + CNT_W'(1);
          end
        end

        ST_ADDMAG: begin
          if (loss_q) avg_loss <= alu_rsp.sum;
          else        avg_gain <= alu_rsp.sum;
          lane <= 1'b0;
        end

        ST_DIV_LOAD: begin
          // sums get the extra fraction bits; smoothed averages have them
          work    <= {(smooth_q ? lane_avg : (lane_avg << AVERAGE_EXTRA_FRACTION)),
                      (WORK_W-AVG_W)'(0)};
          rem     <= '0;
          count   <= '0;
          divisor <= AVG_W'(p_eff);
        end

        ST_DIV: begin
          rem   <= alu_rsp.carry ? alu_rsp.sum : div_a;
          work  <= {work[WORK_W-2:0], alu_rsp.carry};
          count <= count + CNT_W'(1);
          if (div_last) begin
            if (lane) tmp_loss <= {work[AVG_W-2:0], alu_rsp.carry};
            else      tmp_gain <= {work[AVG_W-2:0], alu_rsp.carry};
            lane <= 1'b1;
          end
        end

        ST_TOTAL: begin
          // early results leave the raw sums in place
          if (!early_q) begin
            avg_gain <= tmp_gain;
            avg_loss <= tmp_loss;
          end
          divisor <= alu_rsp.sum;
          value   <= '0;
        end

        ST_PROD_A: begin
          // gain * 100 = gain * (64 + 32 + 4), then scale by 2^16
          work <= {(gain_prod << 6) + (gain_prod << 5), RSI_FRAC'(0)};
        end

        ST_PROD_B: begin
          work[WORK_W-1:RSI_FRAC] <= work[WORK_W-1:RSI_FRAC] + (gain_prod << 2);
          rem   <= '0;
          count <= '0;
        end

        ST_RSI: begin
          rem   <= alu_rsp.carry ? alu_rsp.sum : div_a;
          work  <= {work[WORK_W-2:0], alu_rsp.carry};
          count <= count + CNT_W'(1);
          if (rsi_last) value <= {work[OUT_W-2:0], alu_rsp.carry};
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            rsi_value <= value;
          end
        end

        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction was accepted");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside the emit state");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_RSI) |-> (divisor != '0))
    else $error("division step with a zero divisor");

  a_index_saturates: assert property (@(posedge clk) disable iff (rst)
    (state == ST_START && !restart_q && sample_index == IDX_MAX)
      |=> (sample_index == IDX_MAX))
    else $error("sample index wrapped instead of saturating");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (count < CNT_W'(PERIOD_W)))
    else $error("multiply step count out of range");

endmodule

// File: hdl/wrs_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_addsub: shared 64-bit add/subtract unit
// Adds or subtracts two operands; on subtract the carry out is set when
// a >= b, which drives the restoring division steps.
// ----------------------------------------------------------------------------
module wrs_addsub
  import wrs_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [AVG_W:0] total;

  assign total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
               + (AVG_W+1)'(req.sub);

  assign rsp.sum   = total[AVG_W-1:0];
  assign rsp.carry = total[AVG_W];

endmodule

// File: test/wilder_rsi_stream_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilder_rsi_stream_test: self-checking bench for the Wilder RSI stream block
// Drives price samples through the valid/stall input channel and programs
// the APB registers between phases. A scoreboard object tracks the series
// state and queues the RSI value each sample should produce. Every accepted
// output transaction is checked against the oldest queued value.
// ----------------------------------------------------------------------------
module wilder_rsi_stream_test
  import wrs_pkg::*;
();

  localparam int          EXTRA_FRAC     = 16;
  localparam logic [127:0] RSI_FULL_SCALE = 128'd6553600;  // 100 in Q7.16
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int          SETTLE_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES   = 5_000_000;
  localparam int          RANDOM_ITEMS   = 790;

  // --------------------------------------------------------------------------
  // Scoreboard: series state, register copy and the queue of due RSI values
  // --------------------------------------------------------------------------
  class rsi_tracker;
    logic [PERIOD_W-1:0]   period;
    logic                  early;
    logic [UNSTABLE_W-1:0] unstable;
    logic [31:0]           last_price;
    logic [63:0]           gain_acc;
    logic [63:0]           loss_acc;
    logic [IDX_W-1:0]      next_index;
    logic [31:0]           rsi_due[$];
    int                    failures;

    function new();
      period     = PERIOD_RESET;
      early      = 1'b0;
      unstable   = '0;
      last_price = '0;
      gain_acc   = '0;
      loss_acc   = '0;
      next_index = '0;
      failures   = 0;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_PERIOD: begin
          period = data[PERIOD_W-1:0];
        end
        REG_EARLY: begin
          early = data[0];
        end
        REG_UNSTABLE: begin
          unstable = data[UNSTABLE_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // floor(100 * 2^16 * up / (up + down)), zero when the total is zero
    function logic [63:0] strength(logic [63:0] up, logic [63:0] down);
      logic [63:0]  total;
      logic [127:0] scaled;
      total = up + down;
      if (total == 0) return '0;
      scaled = {64'd0, up} * RSI_FULL_SCALE;
      scaled = scaled / {64'd0, total};
      return scaled[63:0];
    endfunction

    function void note_sample(logic [31:0] px, logic fresh);
      logic [63:0] p;
      logic [63:0] k;
      logic [63:0] lookback;
      logic [63:0] mag;
      logic [63:0] value;
      longint      cur;
      longint      prev;
      longint      d;
      p        = (period == 0) ? 64'd1 : 64'(period);
      k        = fresh ? 64'd0 : 64'(next_index);
      lookback = p + 64'(unstable) - 64'(early);
      value    = '0;
      if (p == 1) begin
        value = 64'(px);
      end else if (k == 0) begin
        gain_acc = '0;
        loss_acc = '0;
      end else begin
        cur  = longint'($signed(px));
        prev = longint'($signed(last_price));
        d    = cur - prev;
        mag  = (d < 0) ? 64'(-d) : 64'(d);
        if (k < p) begin
          // warm-up: raw sums, averaged on the fly for an early value
          if (d < 0) loss_acc += mag;
          else gain_acc += mag;
          value = strength((gain_acc << EXTRA_FRAC) / p, (loss_acc << EXTRA_FRAC) / p);
        end else if (k == p) begin
          if (d < 0) loss_acc += mag;
          else gain_acc += mag;
          gain_acc = (gain_acc << EXTRA_FRAC) / p;
          loss_acc = (loss_acc << EXTRA_FRAC) / p;
          value    = strength(gain_acc, loss_acc);
        end else begin
          gain_acc = gain_acc * (p - 1);
          loss_acc = loss_acc * (p - 1);
          if (d < 0) loss_acc += mag << EXTRA_FRAC;
          else gain_acc += mag << EXTRA_FRAC;
          gain_acc = gain_acc / p;
          loss_acc = loss_acc / p;
          value    = strength(gain_acc, loss_acc);
        end
      end
      last_price = px;
      next_index = (k < 64'(IDX_MAX)) ? k[IDX_W-1:0] + 1'b1 : IDX_MAX;
      if (k >= lookback) rsi_due.push_back(value[31:0]);
    endfunction

    function void check_rsi(logic [31:0] got);
      logic [31:0] want;
      if (rsi_due.size() == 0) begin
        $error("rsi_value: no result expected, actual %h", got);
        failures++;
        return;
      end
      want = rsi_due.pop_front();
      if (got !== want) begin
        $error("rsi_value: expected %h, actual %h", want, got);
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; all inputs are driven to known values from time zero
  // --------------------------------------------------------------------------
  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    psel      = 1'b0;
  logic                    penable   = 1'b0;
  logic                    pwrite    = 1'b0;
  logic [PADDR_W-1:0]      paddr     = '0;
  logic [PDATA_W-1:0]      pwdata    = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic signed [31:0]      price     = '0;
  logic                    restart   = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] rsi_value;

  rsi_tracker  tracker = new();

  // Idle controls shared between the stimulus and the receiver process
  int          tx_idle_max = 13;
  int          rx_idle_max = 13;
  int          rx_hold_req = 0;
  int          lookback_now;
  logic [31:0] walk_price = '0;
  int unsigned cycle_count = 0;

  wilder_rsi_stream dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .price     (price),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rsi_value (rsi_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest legal run stays well below this
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Monitor both channels on the pre-edge values; check output first so
  // the queue order never depends on process order within the step
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_rsi(rsi_value);
      if (in_valid && !in_stall) tracker.note_sample(price, restart);
    end
  end

  // Receiver: draw a stall per transaction; honor one long hold-off when
  // requested so the block backs up into its input channel
  initial begin
    int stall_len;
    forever begin
      if (rx_hold_req > 0) begin
        stall_len   = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall_len = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Offer one sample and return at the edge that accepts it. Keep valid
  // high across back-to-back transactions; drop it only for a real gap.
  task automatic send_sample(input logic [31:0] px, input logic fresh);
    int gap;
    gap = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    price    <= px;
    restart  <= fresh;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Wait for every due result, then give the sequencer time to finish a
  // sample that produces no result
  task automatic drain();
    while (tracker.rsi_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // Reprogram all three registers with the block idle
  task automatic configure(input int per, input bit early_on, input int unst);
    in_valid <= 1'b0;
    drain();
    apb_write(REG_PERIOD, 32'(per));
    apb_write(REG_EARLY, 32'(early_on));
    apb_write(REG_UNSTABLE, 32'(unst));
    lookback_now = ((per == 0) ? 1 : per) + unst - (early_on ? 1 : 0);
  endtask

  // Mostly a random walk, with jumps to arbitrary values and to both rails
  function automatic logic [31:0] wander_price();
    case ($urandom_range(0, 9))
      0: walk_price = $urandom;
      1: begin
        // hold the price: a change of zero
      end
      2: walk_price = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: walk_price = walk_price + 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
    endcase
    return walk_price;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] corner_prices [16];
    int          random_sent;
    int          phase_sent;
    int          phase;
    int          shape;
    int          len;
    int          per;
    int          unst;
    bit          early_on;

    corner_prices = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
                      32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_8000};
    random_sent = 0;
    phase       = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset settings (period 14). First sample has no restart flag, so it
    // must still open the series. Rail-to-rail swings stress the sums.
    lookback_now = 14;
    foreach (corner_prices[i]) send_sample(corner_prices[i], 1'b0);

    // Period 2 in early mode: a result on the second sample, taken from the
    // raw sums; the repeated price gives a zero total and hence zero
    configure(2, 1'b1, 0);
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0003_0000, 1'b0);
    send_sample(32'h0002_0000, 1'b0);

    // Period zero acts as pass-through; a write to the spare slot is ignored
    configure(0, 1'b0, 0);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);

    // Continue the series unflagged, up to the largest period and warm-up
    // length, so the averages pick up from pass-through state
    configure(3, 1'b0, 65535);
    repeat (12) send_sample(wander_price(), 1'b0);
    configure(2047, 1'b1, 65535);
    repeat (12) send_sample(wander_price(), 1'b0);
    configure(1024, 1'b0, 7);
    repeat (12) send_sample(wander_price(), 1'b0);

    // Random phases: each picks new settings, then mostly complete series
    // with random content, some truncated series and some unflagged noise
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: per = 0;
        1: per = 1;
        2: per = 2;
        3: per = $urandom_range(25, 40);
        default: per = $urandom_range(3, 16);
      endcase
      early_on = $urandom_range(0, 1);
      unst     = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 2);
      configure(per, early_on, unst);

      case (phase % 4)
        0: begin
          tx_idle_max = 13;
          rx_idle_max = 13;
        end
        1: begin
          tx_idle_max = 0;
          rx_idle_max = 0;
        end
        2: begin
          tx_idle_max = 0;
          rx_idle_max = 13;
        end
        default: begin
          tx_idle_max = 13;
          rx_idle_max = 0;
        end
      endcase
      // One long receiver hold-off while the sender keeps offering samples
      if (phase == 0) rx_hold_req = 600;

      phase_sent = 0;
      while (phase_sent < 100) begin
        shape = $urandom_range(0, 9);
        if (shape < 7) len = lookback_now + $urandom_range(0, 12);
        else if (shape < 9) len = $urandom_range(1, lookback_now + 1);
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          send_sample(wander_price(), (i == 0) && (shape != 9));
        end
        phase_sent  += len;
        random_sent += len;
      end
      phase++;
    end

    // Flush: no new samples, wait out every due result and the tail
    in_valid <= 1'b0;
    drain();
    if (tracker.failures == 0 && tracker.rsi_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: wilder_rsi_stream.f
hdl/wrs_pkg.sv
hdl/wrs_addsub.sv
hdl/wilder_rsi_stream.sv
test/wilder_rsi_stream_test.sv
